// ===== rtl/gpp_pkg.sv =====
//------------------------------------------------------------------------------
// gpp_pkg
// Shared types and field widths for the GGA position parser.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gpp_pkg;

  localparam int MIN_W     = 20;  // minutes accumulator, minutes times 10000
  localparam int LAT_DEG_W = 7;
  localparam int LON_DEG_W = 10;
  localparam int LAT_Q_W   = 15;
  localparam int LON_Q_W   = 18;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_sentence;
  } char_item_t;

  typedef struct packed {
    logic [LAT_Q_W-1:0] latitude_q8;
    logic [LON_Q_W-1:0] longitude_q8;
    logic               recognized;
    logic               format_error;
  } fix_item_t;

  // Coordinates captured at the end of a sentence; zeroed when not usable
  typedef struct packed {
    logic                 recognized;
    logic                 format_error;
    logic [LAT_DEG_W-1:0] lat_deg;
    logic [MIN_W-1:0]     lat_min;
    logic [LON_DEG_W-1:0] lon_deg;
    logic [MIN_W-1:0]     lon_min;
  } capture_t;

  // Stage loads for the conversion lanes
  typedef struct packed {
    logic load_prod;
    logic load_rem;
    logic load_out;
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/gpp_sentence_tracker.sv =====
//------------------------------------------------------------------------------
// gpp_sentence_tracker
// Follows the sentence one character at a time, checks the type field,
// collects the latitude and longitude digits and captures them at the end.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpp_sentence_tracker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  gpp_pkg::char_item_t   item,
  input  logic                  cap_adv,
  output logic                  cap_valid,
  output gpp_pkg::capture_t     cap
);
  import gpp_pkg::*;

  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_G     = 8'h47;
  localparam logic [7:0] CHAR_P     = 8'h50;

  localparam logic [3:0] FIELD_TYPE     = 4'd0;
  localparam logic [3:0] FIELD_LAT      = 4'd2;
  localparam logic [3:0] FIELD_LON      = 4'd4;
  localparam logic [3:0] LAT_CLOSED     = 4'd3;
  localparam logic [3:0] LON_CLOSED     = 4'd5;
  localparam logic [3:0] COUNT_MAX      = 4'd15;
  localparam logic [2:0] TYPE_LEN       = 3'd5;
  localparam logic [3:0] LAT_LEN        = 4'd9;
  localparam logic [3:0] LON_LEN        = 4'd10;
  localparam logic [3:0] LAT_DEG_DIGITS = 4'd2;
  localparam logic [3:0] LON_DEG_DIGITS = 4'd3;
  localparam logic [3:0] LAT_DOT_POS    = 4'd4;
  localparam logic [3:0] LON_DOT_POS    = 4'd5;

  function automatic logic [7:0] type_char(input logic [2:0] idx);
    case (idx)
      3'd0:    return CHAR_G;
      3'd1:    return CHAR_P;
      3'd2:    return CHAR_G;
      3'd3:    return CHAR_G;
      3'd4:    return CHAR_A;
      default: return 8'h00;
    endcase
  endfunction

  logic [2:0]           type_match_index, type_match_index_next;
  logic                 type_ok, type_ok_next;
  logic [3:0]           comma_count, comma_count_next;
  logic [3:0]           field_char_count, field_char_count_next;
  logic [LAT_DEG_W-1:0] lat_degrees_acc, lat_degrees_acc_next;
  logic [MIN_W-1:0]     lat_minutes_acc, lat_minutes_acc_next;
  logic [LON_DEG_W-1:0] lon_degrees_acc, lon_degrees_acc_next;
  logic [MIN_W-1:0]     lon_minutes_acc, lon_minutes_acc_next;
  logic [1:0]           digit_error, digit_error_next;

  logic [7:0]  c;
  logic        is_digit;
  logic [3:0]  digit_val;
  logic [10:0] lat_deg_step;
  logic [13:0] lon_deg_step;
  logic [23:0] lat_min_step;
  logic [23:0] lon_min_step;
  logic        rec, lat_bad, lon_bad;
  capture_t    cap_next;

  assign c         = item.char_code;
  assign is_digit  = c inside {[CHAR_0:CHAR_9]};
  assign digit_val = is_digit ? 4'(c - CHAR_0) : 4'd0;

  assign lat_deg_step = 11'(lat_degrees_acc) * 11'd10 + 11'(digit_val);
  assign lon_deg_step = 14'(lon_degrees_acc) * 14'd10 + 14'(digit_val);
  assign lat_min_step = 24'(lat_minutes_acc) * 24'd10 + 24'(digit_val);
  assign lon_min_step = 24'(lon_minutes_acc) * 24'd10 + 24'(digit_val);

  always_comb begin
    type_match_index_next = type_match_index;
    type_ok_next          = type_ok;
    comma_count_next      = comma_count;
    field_char_count_next = field_char_count;
    lat_degrees_acc_next  = lat_degrees_acc;
    lat_minutes_acc_next  = lat_minutes_acc;
    lon_degrees_acc_next  = lon_degrees_acc;
    lon_minutes_acc_next  = lon_minutes_acc;
    digit_error_next      = digit_error;

    if (comma_count == FIELD_TYPE && field_char_count == 4'd0) begin
      // start mark: skip it, whatever it is
      field_char_count_next = 4'd1;
    end else if (c == CHAR_COMMA) begin
      if (comma_count == FIELD_TYPE && type_match_index != TYPE_LEN) begin
        type_ok_next = 1'b0;
      end
      if (comma_count == FIELD_LAT && field_char_count != LAT_LEN) begin
        digit_error_next[0] = 1'b1;
      end
      if (comma_count == FIELD_LON && field_char_count != LON_LEN) begin
        digit_error_next[1] = 1'b1;
      end
      if (comma_count != COUNT_MAX) begin
        comma_count_next = comma_count + 4'd1;
      end
      field_char_count_next = 4'd0;
    end else begin
      case (comma_count)
        FIELD_TYPE: begin
          if (type_match_index < TYPE_LEN && c == type_char(type_match_index)) begin
            type_match_index_next = type_match_index + 3'd1;
          end else begin
            type_ok_next = 1'b0;
          end
        end
        FIELD_LAT: begin
          if (field_char_count >= LAT_LEN) begin
            digit_error_next[0] = 1'b1;
          end else if (field_char_count == LAT_DOT_POS) begin
            if (c != CHAR_DOT) digit_error_next[0] = 1'b1;
          end else if (!is_digit) begin
            digit_error_next[0] = 1'b1;
          end else if (field_char_count < LAT_DEG_DIGITS) begin
            lat_degrees_acc_next = lat_deg_step[LAT_DEG_W-1:0];
          end else begin
            lat_minutes_acc_next = lat_min_step[MIN_W-1:0];
          end
        end
        FIELD_LON: begin
          if (field_char_count >= LON_LEN) begin
            digit_error_next[1] = 1'b1;
          end else if (field_char_count == LON_DOT_POS) begin
            if (c != CHAR_DOT) digit_error_next[1] = 1'b1;
          end else if (!is_digit) begin
            digit_error_next[1] = 1'b1;
          end else if (field_char_count < LON_DEG_DIGITS) begin
            lon_degrees_acc_next = lon_deg_step[LON_DEG_W-1:0];
          end else begin
            lon_minutes_acc_next = lon_min_step[MIN_W-1:0];
          end
        end
        default: ;
      endcase
      if (field_char_count != COUNT_MAX) begin
        field_char_count_next = field_char_count + 4'd1;
      end
    end
  end

  // Form the capture from the state after the final character
  always_comb begin
    rec     = type_ok_next && (comma_count_next != FIELD_TYPE);
    lat_bad = digit_error_next[0] || (comma_count_next < LAT_CLOSED);
    lon_bad = digit_error_next[1] || (comma_count_next < LON_CLOSED);
    cap_next.recognized   = rec;
    cap_next.format_error = rec && (lat_bad || lon_bad);
    cap_next.lat_deg      = (rec && !lat_bad) ? lat_degrees_acc_next : '0;
    cap_next.lat_min      = (rec && !lat_bad) ? lat_minutes_acc_next : '0;
    cap_next.lon_deg      = (rec && !lon_bad) ? lon_degrees_acc_next : '0;
    cap_next.lon_min      = (rec && !lon_bad) ? lon_minutes_acc_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && item.end_of_sentence)) begin
      type_match_index <= '0;
      type_ok          <= 1'b1;
      comma_count      <= '0;
      field_char_count <= '0;
      lat_degrees_acc  <= '0;
      lat_minutes_acc  <= '0;
      lon_degrees_acc  <= '0;
      lon_minutes_acc  <= '0;
      digit_error      <= '0;
    end else if (take) begin
      type_match_index <= type_match_index_next;
      type_ok          <= type_ok_next;
      comma_count      <= comma_count_next;
      field_char_count <= field_char_count_next;
      lat_degrees_acc  <= lat_degrees_acc_next;
      lat_minutes_acc  <= lat_minutes_acc_next;
      lon_degrees_acc  <= lon_degrees_acc_next;
      lon_minutes_acc  <= lon_minutes_acc_next;
      digit_error      <= digit_error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_valid <= 1'b0;
    end else if (take && item.end_of_sentence) begin
      cap_valid <= 1'b1;
    end else if (cap_adv) begin
      cap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.end_of_sentence) begin
      cap <= cap_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gpp_deg_lane.sv =====
//------------------------------------------------------------------------------
// gpp_deg_lane
// Converts degrees plus minutes (times 10000) to fixed-point degrees:
// deg * 2^F + floor(min * 2^F / 600000), by reciprocal multiply and one
// remainder correction over three registered stages.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpp_deg_lane #(
  parameter int FRACTION_BITS = 8,
  parameter int DEG_W         = 7,
  parameter int OUT_W         = 15
) (
  input  logic                              clk,
  input  gpp_pkg::lane_ctrl_t               ctrl,
  input  logic [DEG_W-1:0]                  deg,
  input  logic [gpp_pkg::MIN_W-1:0]         minutes,
  output logic [OUT_W-1:0]                  q
);
  import gpp_pkg::*;

  // 600000 = 2^6 * 9375: drop the power of two first, then divide by 9375
  localparam int MINUTE_SHIFT = 6;
  localparam int DIVISOR      = 9375;
  localparam int DIV_W        = $clog2(DIVISOR);
  localparam int NW           = MIN_W + FRACTION_BITS;
  localparam int MW           = NW - MINUTE_SHIFT;
  localparam int QW           = MW - DIV_W + 1;
  localparam int REM_W        = DIV_W + 1;
  localparam int SUM_W        = DEG_W + FRACTION_BITS + OUT_W + 1;
  localparam logic [QW-1:0] RECIP = QW'(((64'd1 << MW) / 64'(DIVISOR)));

  logic [NW-1:0]       n;
  logic [MW-1:0]       m;
  logic [MW:0]         m_x;
  logic [MW+QW-1:0]    prod_q;
  logic [QW+DIV_W-1:0] prod_back;
  logic                round_up;
  logic [SUM_W-1:0]    total;

  logic [DEG_W-1:0]    prod_deg;
  logic [QW-1:0]       prod_qest;
  logic [REM_W-1:0]    prod_mlow;
  logic [DEG_W-1:0]    rem_deg;
  logic [QW-1:0]       rem_qest;
  logic [REM_W-1:0]    rem_low;

  assign n      = NW'(minutes) << FRACTION_BITS;
  assign m      = n[NW-1:MINUTE_SHIFT];
  assign m_x    = {1'b0, m};
  assign prod_q = (MW+QW)'(m) * (MW+QW)'(RECIP);

  // quotient estimate is exact or one low
  always_ff @(posedge clk) begin
    if (ctrl.load_prod) begin
      prod_deg  <= deg;
      prod_qest <= prod_q[MW+QW-1:MW];
      prod_mlow <= m_x[REM_W-1:0];
    end
  end

  // remainder is below twice the divisor, so its low bits suffice
  assign prod_back = (QW+DIV_W)'(prod_qest) * (QW+DIV_W)'(DIVISOR);

  always_ff @(posedge clk) begin
    if (ctrl.load_rem) begin
      rem_deg  <= prod_deg;
      rem_qest <= prod_qest;
      rem_low  <= prod_mlow - prod_back[REM_W-1:0];
    end
  end

  assign round_up = rem_low >= REM_W'(DIVISOR);
  assign total    = (SUM_W'(rem_deg) << FRACTION_BITS) + SUM_W'(rem_qest)
                  + SUM_W'(round_up);

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      q <= total[OUT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gga_position_parser_unit.sv =====
//------------------------------------------------------------------------------
// gga_position_parser_unit
// GGA sentence parser: one character per transaction in, one position fix
// per sentence out.
//------------------------------------------------------------------------------
// Channel  Direction  Handshake               Payload
// char     in         char_valid / char_ready  gpp_pkg::char_item_t
// fix      out        fix_valid  / fix_ready   gpp_pkg::fix_item_t
//
// One character is taken per cycle while char_ready is high. The fix for a
// sentence passes through the capture register, reciprocal multiply,
// remainder correction and output register after its final character is taken.
// Reset clears the parse state and every stage valid.
// Stages move independently; char_ready drops only when all four stages
// hold a fix and fix_ready is low.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gga_position_parser_unit #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 char_valid,
  output logic                 char_ready,
  input  gpp_pkg::char_item_t  char_data,
  output logic                 fix_valid,
  input  logic                 fix_ready,
  output gpp_pkg::fix_item_t   fix_data
);
  import gpp_pkg::*;

  logic       cap_valid, prod_valid, rem_valid, out_valid;
  logic       cap_adv, prod_adv, rem_adv, out_adv;
  logic       prod_rec, prod_fe, rem_rec, rem_fe, out_rec, out_fe;
  logic       take;
  capture_t   cap;
  lane_ctrl_t ctrl;
  logic [LAT_Q_W-1:0] lat_q;
  logic [LON_Q_W-1:0] lon_q;

  assign out_adv  = out_valid && fix_ready;
  assign rem_adv  = rem_valid && (!out_valid || out_adv);
  assign prod_adv = prod_valid && (!rem_valid || rem_adv);
  assign cap_adv  = cap_valid && (!prod_valid || prod_adv);

  assign char_ready = !cap_valid || cap_adv;
  assign take       = char_valid && char_ready;

  assign ctrl.load_prod = cap_adv;
  assign ctrl.load_rem  = prod_adv;
  assign ctrl.load_out  = rem_adv;

  gpp_sentence_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (char_data),
    .cap_adv   (cap_adv),
    .cap_valid (cap_valid),
    .cap       (cap)
  );

  gpp_deg_lane #(
    .FRACTION_BITS (FRACTION_BITS),
    .DEG_W         (LAT_DEG_W),
    .OUT_W         (LAT_Q_W)
  ) u_lat_lane (
    .clk     (clk),
    .ctrl    (ctrl),
    .deg     (cap.lat_deg),
    .minutes (cap.lat_min),
    .q       (lat_q)
  );

  gpp_deg_lane #(
    .FRACTION_BITS (FRACTION_BITS),
    .DEG_W         (LON_DEG_W),
    .OUT_W         (LON_Q_W)
  ) u_lon_lane (
    .clk     (clk),
    .ctrl    (ctrl),
    .deg     (cap.lon_deg),
    .minutes (cap.lon_min),
    .q       (lon_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      rem_valid  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cap_adv)       prod_valid <= 1'b1;
      else if (prod_adv) prod_valid <= 1'b0;
      if (prod_adv)      rem_valid  <= 1'b1;
      else if (rem_adv)  rem_valid  <= 1'b0;
      if (rem_adv)       out_valid  <= 1'b1;
      else if (out_adv)  out_valid  <= 1'b0;
    end
  end

  // carry the flags alongside the lanes
  always_ff @(posedge clk) begin
    if (cap_adv) begin
      prod_rec <= cap.recognized;
      prod_fe  <= cap.format_error;
    end
    if (prod_adv) begin
      rem_rec <= prod_rec;
      rem_fe  <= prod_fe;
    end
    if (rem_adv) begin
      out_rec <= rem_rec;
      out_fe  <= rem_fe;
    end
  end

  assign fix_valid             = out_valid;
  assign fix_data.latitude_q8  = lat_q;
  assign fix_data.longitude_q8 = lon_q;
  assign fix_data.recognized   = out_rec;
  assign fix_data.format_error = out_fe;

endmodule

`default_nettype wire

// ===== rtl/gpp_checker.sv =====
//------------------------------------------------------------------------------
// gpp_checker
// Port-level checks for the GGA position parser, bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpp_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                char_ready,
  input wire logic                fix_valid,
  input wire logic                fix_ready,
  input wire gpp_pkg::fix_item_t  fix_data
);
  import gpp_pkg::*;

  // an error flag only ever comes with a recognized sentence
  a_error_needs_rec: assert property (@(posedge clk) disable iff (rst)
    fix_valid |-> (fix_data.recognized || !fix_data.format_error))
    else $error("format_error set on an unrecognized sentence");

  // an unrecognized sentence carries zero positions
  a_unrec_zero: assert property (@(posedge clk) disable iff (rst)
    (fix_valid && !fix_data.recognized) |->
      (fix_data.latitude_q8 == '0 && fix_data.longitude_q8 == '0))
    else $error("unrecognized sentence with nonzero position");

  // with the output free to move, the pipeline drains and input is open
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!fix_valid || fix_ready) |-> char_ready)
    else $error("char_ready low while output is free");

  a_fix_hold: assert property (@(posedge clk) disable iff (rst)
    (fix_valid && !fix_ready) |=> (fix_valid && $stable(fix_data)))
    else $error("stalled fix changed or dropped");

endmodule

bind gga_position_parser_unit gpp_checker u_gpp_checker (
  .clk        (clk),
  .rst        (rst),
  .char_ready (char_ready),
  .fix_valid  (fix_valid),
  .fix_ready  (fix_ready),
  .fix_data   (fix_data)
);

`default_nettype wire

// ===== tb/tb_gga_position_parser_unit.sv =====
//------------------------------------------------------------------------------
// tb_gga_position_parser_unit
// Feeds GGA sentences one character per transaction and checks each position
// fix against a predictor of the parser. A table of directed sentences covers
// the field extremes, wrong sentence types and malformed coordinates. After
// it comes a random mix of well-formed sentences, damaged ones and noise,
// under two patterns of sender and receiver stalls and one without stalls.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gga_position_parser_unit;

  import gpp_pkg::*;

  localparam int                FRAC         = 8;
  localparam int                LAT_LEN      = 9;
  localparam int                LON_LEN      = 10;
  localparam longint unsigned   MINUTE_SCALE = 600000;
  localparam logic [39:0]       TYPE_TEXT    = "GPGGA";
  localparam int                DIR_ROWS     = 18;
  localparam int                PHASE_CHARS  = 510;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       char_valid = 1'b0;
  logic       char_ready;
  char_item_t char_data = '0;
  logic       fix_valid;
  logic       fix_ready = 1'b0;
  fix_item_t  fix_data;

  gga_position_parser_unit #(
    .FRACTION_BITS(FRAC)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .char_data (char_data),
    .fix_valid (fix_valid),
    .fix_ready (fix_ready),
    .fix_data  (fix_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Parser state as the predictor sees it; index 0 is latitude, 1 longitude
  logic [2:0]  type_idx;
  logic        type_good;
  logic [3:0]  commas;
  logic [3:0]  field_len;
  logic [9:0]  deg_acc [2];
  logic [19:0] min_acc [2];
  logic [1:0]  bad_coord;

  fix_item_t   pending_fixes [$];
  fix_item_t   typed_row_fix = '0;
  logic        typed_row_on = 1'b0;
  int          fault_count = 0;
  int          send_idle_pct = 25;
  int          recv_idle_pct = 75;
  int          sent_chars;
  logic [7:0]  line_buf [$];

  task automatic clear_parse();
    type_idx   = '0;
    type_good  = 1'b1;
    commas     = '0;
    field_len  = '0;
    deg_acc[0] = '0;
    deg_acc[1] = '0;
    min_acc[0] = '0;
    min_acc[1] = '0;
    bad_coord  = '0;
  endtask

  function automatic longint unsigned q_degrees(input longint unsigned deg,
                                                input longint unsigned mins);
    return ((deg * MINUTE_SCALE + mins) << FRAC) / MINUTE_SCALE;
  endfunction

  task automatic take_coord_char(input logic [7:0] c, input int k);
    int         pos;
    int         deg_n;
    int         len;
    logic       is_digit;
    logic [3:0] d;
    pos      = field_len;
    deg_n    = (k == 1) ? 3 : 2;
    len      = (k == 1) ? LON_LEN : LAT_LEN;
    is_digit = (c >= "0") && (c <= "9");
    d        = is_digit ? 4'(c - "0") : 4'd0;
    if (pos >= len) begin
      bad_coord[k] = 1'b1;
    end else if (pos == deg_n + 2) begin
      if (c != ".") bad_coord[k] = 1'b1;
    end else if (!is_digit) begin
      bad_coord[k] = 1'b1;
    end else if (pos < deg_n) begin
      deg_acc[k] = 10'((deg_acc[k] * 10 + d) & ((k == 1) ? 10'h3FF : 10'h07F));
    end else begin
      min_acc[k] = 20'(min_acc[k] * 10 + d);
    end
  endtask

  task automatic parse_char(input logic [7:0] c, input logic eos,
                            output logic done, output fix_item_t fix);
    logic            rec;
    logic            lat_bad;
    logic            lon_bad;
    longint unsigned lat_q;
    longint unsigned lon_q;
    done = eos;
    fix  = '0;
    // the start mark is skipped whatever it is
    if (commas == 0 && field_len == 0) begin
      field_len = 4'd1;
    end else if (c == ",") begin
      if (commas == 0 && type_idx != 5) type_good = 1'b0;
      if (commas == 2 && field_len != LAT_LEN) bad_coord[0] = 1'b1;
      if (commas == 4 && field_len != LON_LEN) bad_coord[1] = 1'b1;
      if (commas != 15) commas++;
      field_len = 4'd0;
    end else begin
      if (commas == 0) begin
        if (type_idx < 5 && c == TYPE_TEXT[39 - 8 * type_idx -: 8]) type_idx++;
        else type_good = 1'b0;
      end else if (commas == 2) begin
        take_coord_char(c, 0);
      end else if (commas == 4) begin
        take_coord_char(c, 1);
      end
      if (field_len != 15) field_len++;
    end
    if (eos) begin
      rec     = type_good && (commas >= 1);
      lat_bad = bad_coord[0] || (commas < 3);
      lon_bad = bad_coord[1] || (commas < 5);
      lat_q   = lat_bad ? 0 : q_degrees(deg_acc[0], min_acc[0]);
      lon_q   = lon_bad ? 0 : q_degrees(deg_acc[1], min_acc[1]);
      if (rec) begin
        fix.latitude_q8  = lat_q[LAT_Q_W-1:0];
        fix.longitude_q8 = lon_q[LON_Q_W-1:0];
        fix.recognized   = 1'b1;
        fix.format_error = lat_bad || lon_bad;
      end
      clear_parse();
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk) fix_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk) begin : watch
    logic      has_fix;
    fix_item_t fix;
    fix_item_t exp_fix;
    if (!rst && char_valid && char_ready) begin
      parse_char(char_data.char_code, char_data.end_of_sentence, has_fix, fix);
      if (has_fix) pending_fixes.push_back(typed_row_on ? typed_row_fix : fix);
    end
    if (!rst && fix_valid && fix_ready) begin
      if (pending_fixes.size() == 0) begin
        $error("fix transaction with no sentence pending");
        fault_count++;
      end else begin
        exp_fix = pending_fixes.pop_front();
        check_field("latitude_q8", exp_fix.latitude_q8, fix_data.latitude_q8);
        check_field("longitude_q8", exp_fix.longitude_q8, fix_data.longitude_q8);
        check_field("recognized", exp_fix.recognized, fix_data.recognized);
        check_field("format_error", exp_fix.format_error, fix_data.format_error);
      end
    end
  end

  // Hold valid and payload until the transaction is taken
  task automatic send_char(input logic [7:0] code, input logic eos);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_data  <= '{char_code: code, end_of_sentence: eos};
    @(posedge clk);
    while (!char_ready) @(posedge clk);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
    sent_chars += line_buf.size();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  function automatic logic [7:0] rand_digit();
    logic [7:0] d;
    d = 8'($urandom_range(0, 9));
    return "0" + d;
  endfunction

  task automatic push_coord(input int deg_n);
    repeat (deg_n + 2) line_buf.push_back(rand_digit());
    line_buf.push_back(".");
    repeat (4) line_buf.push_back(rand_digit());
  endtask

  function automatic fix_item_t flags_only(input logic rec, input logic fe);
    return {{LAT_Q_W{1'b0}}, {LON_Q_W{1'b0}}, rec, fe};
  endfunction

  // Directed sentences; typed results only where they are plain to see
  task automatic directed_row(input int row, output string text,
                              output logic typed, output fix_item_t want);
    typed = 1'b1;
    want  = flags_only(1'b0, 1'b0);
    case (row)
      0:  begin text = "$GPGGA,,0000.0000,,00000.0000,*"; want = flags_only(1'b1, 1'b0); end
      1:  begin text = "$GPGGA,1,9999.9999,S,99999.9999,W"; typed = 1'b0; end
      2:  begin text = "$GPGGA,,4807.0380,N,01131.0000,E"; typed = 1'b0; end
      3:  begin text = "$GPGGA,,1075.5000,,12360.0000,"; typed = 1'b0; end
      4:  text = "$GPGGB,,4807.0380,,01131.0000,";
      5:  text = "$GPGGA";
      6:  text = "$GPGGAA,,4807.0380,,01131.0000,";
      7:  text = "$GPGG,,4807.0380,,01131.0000,";
      8:  text = "$";
      9:  begin text = ",GPGGA,,0000.0000,,00000.0000,,"; want = flags_only(1'b1, 1'b0); end
      10: begin text = "$GPGGA,,48a7.0380,,00000.0000,"; want = flags_only(1'b1, 1'b1); end
      11: begin text = "$GPGGA,,4807.0380,,0113.10000,"; typed = 1'b0; end
      12: begin text = "$GPGGA,,4807.038,,01131.0000,"; typed = 1'b0; end
      13: begin text = "$GPGGA,,4807.03800,,01131.0000,"; typed = 1'b0; end
      14: begin text = "$GPGGA,,0000.0000,,00000.0000"; want = flags_only(1'b1, 1'b1); end
      15: begin text = "$GPGGA,,,,,"; want = flags_only(1'b1, 1'b1); end
      16: text = "$\377GPGGA,,,,";
      default: begin
        text = "$GPGGA,,,,,,,,,,,,,,,,,,,,*";
        want = flags_only(1'b1, 1'b1);
      end
    endcase
  endtask

  // Mostly well-formed sentences with random content, some damaged, some noise
  task automatic build_sentence();
    int         kind;
    int         pick;
    int         n;
    logic [7:0] b;
    line_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      n = $urandom_range(1, 24);
      repeat (n) begin
        b = 8'($urandom_range(0, 255));
        line_buf.push_back(b);
      end
    end else begin
      line_buf.push_back("$");
      pick = $urandom_range(0, 99);
      if (pick < 80) push_text("GPGGA");
      else if (pick < 87) push_text("GPGG");
      else if (pick < 93) push_text("GPGGAA");
      else push_text("GPGSA");
      line_buf.push_back(",");
      n = $urandom_range(0, 12);
      repeat (n) line_buf.push_back(rand_digit());
      line_buf.push_back(",");
      push_coord(2);
      line_buf.push_back(",");
      line_buf.push_back($urandom_range(0, 1) ? "N" : "S");
      line_buf.push_back(",");
      push_coord(3);
      line_buf.push_back(",");
      n = $urandom_range(0, 12);
      repeat (n) begin
        repeat ($urandom_range(0, 3)) line_buf.push_back(rand_digit());
        line_buf.push_back(",");
      end
      if ($urandom_range(0, 1)) line_buf.push_back("*");
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        b = 8'($urandom_range(0, 255));
        line_buf[$urandom_range(0, line_buf.size() - 1)] = b;
      end else if (pick < 25) begin
        n = $urandom_range(0, 2);
        b = (n == 0) ? "." : (n == 1) ? "," : rand_digit();
        line_buf[$urandom_range(1, line_buf.size() - 1)] = b;
      end else if (pick < 40) begin
        n = $urandom_range(1, line_buf.size());
        while (line_buf.size() > n) void'(line_buf.pop_back());
      end
    end
  endtask

  initial begin : stimulus
    string     text;
    logic      typed;
    fix_item_t want;
    clear_parse();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      directed_row(r, text, typed, want);
      line_buf.delete();
      push_text(text);
      typed_row_on  <= typed;
      typed_row_fix <= want;
      send_line();
    end
    typed_row_on <= 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 25; recv_idle_pct <= 75; end
        1: begin send_idle_pct = 75; recv_idle_pct <= 25; end
        default: begin send_idle_pct = 0; recv_idle_pct <= 0; end
      endcase
      sent_chars = 0;
      while (sent_chars < PHASE_CHARS) begin
        build_sentence();
        send_line();
      end
    end
    char_valid <= 1'b0;

    while (pending_fixes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fault_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
